// ===== hdl/brd_pkg.sv =====
// brd_pkg: shared constants, payload words and controller/datapath links
// for the graph route search block. No dependencies.
package brd_pkg;

  localparam int MAX_V    = 16;
  localparam int VERT_W   = $clog2(MAX_V);
  localparam int CNT_W    = VERT_W + 1;
  localparam int EDGE_AW  = 2 * VERT_W;
  localparam int EDGE_N   = MAX_V * MAX_V;
  localparam int KM_W     = 16;
  localparam int DIST_W   = 20;
  localparam int NV_W     = 5;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [NV_W-1:0]   NV_RESET = NV_W'(16);

  localparam logic OP_EDGE  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic              op;
    logic [3:0]        edge_from;
    logic [3:0]        edge_to;
    logic              edge_exists;
    logic [KM_W-1:0]   edge_km;
    logic [3:0]        start_vertex;
    logic [3:0]        goal_vertex;
  } item_t;

  typedef struct packed {
    logic              route_found;
    logic [DIST_W-1:0] total_distance;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic wr_edge;
    logic init;
    logic deq;
    logic scan;
    logic finish;
    logic found;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic q_empty;
    logic is_goal;
    logic scan_done;
  } stat_t;

endpackage

// ===== hdl/brd_ram.sv =====
// brd_ram: generic simple dual-port RAM, one write and one registered read.
// Depends on nothing.
module brd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/brd_ctrl.sv =====
// brd_ctrl: sequencing state machine for edge writes and route queries.
// Depends on brd_pkg.
module brd_ctrl import brd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  op,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEQ  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start && op == OP_EDGE) begin
          cmd.wr_edge = 1'b1;
        end else if (start && op == OP_QUERY) begin
          cmd.init   = 1'b1;
          state_next = S_DEQ;
        end
      end
      S_DEQ: begin
        if (stat.q_empty) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else if (stat.is_goal) begin
          cmd.finish = 1'b1;
          cmd.found  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.deq    = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DEQ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hdl/brd_dp.sv =====
// brd_dp: edge matrix, search queue, visited flags and distance registers.
// Depends on brd_pkg and brd_ram.
module brd_dp import brd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [NV_W-1:0] cfg_wdata,
  input  item_t           item,
  input  cmd_t            cmd,
  output stat_t           stat,
  output logic            done,
  output result_t         result
);

  logic [NV_W-1:0]    num_vertices;
  logic [CNT_W-1:0]   limit;
  logic [VERT_W-1:0]  goal;
  logic [CNT_W-1:0]   head;
  logic [CNT_W-1:0]   tail;
  logic [VERT_W-1:0]  queue [MAX_V];
  logic [DIST_W-1:0]  reach [MAX_V];
  logic [MAX_V-1:0]   visited;
  logic [VERT_W-1:0]  cur_v;
  logic [DIST_W-1:0]  cur_dist;
  logic [CNT_W-1:0]   n_rd;
  logic               ev_valid;
  logic [VERT_W-1:0]  ev_n;
  logic               ev_vld;
  logic [EDGE_N-1:0]  edge_vld;

  logic [EDGE_AW-1:0] waddr;
  logic [EDGE_AW-1:0] raddr;
  logic [KM_W:0]      rdata;
  logic [VERT_W-1:0]  head_v;
  logic               issue;
  logic               hit;
  logic [DIST_W:0]    sum;
  logic [DIST_W-1:0]  sum_sat;

  assign waddr = {item.edge_from, item.edge_to};
  assign raddr = {cur_v, n_rd[VERT_W-1:0]};

  brd_ram #(
    .WIDTH (KM_W + 1),
    .DEPTH (EDGE_N)
  ) u_edge_ram (
    .clk   (clk),
    .we    (cmd.wr_edge),
    .waddr (waddr),
    .wdata ({item.edge_exists, item.edge_km}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign head_v  = queue[head[VERT_W-1:0]];
  assign issue   = cmd.scan && (n_rd < limit);
  // entry never written reads as absent
  assign hit     = ev_valid && ev_vld && rdata[KM_W] && !visited[ev_n]
                   && (tail < CNT_W'(MAX_V));
  assign sum     = {1'b0, cur_dist} + (DIST_W + 1)'(rdata[KM_W-1:0]);
  assign sum_sat = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  assign stat.q_empty   = (head == tail);
  assign stat.is_goal   = (head_v == goal);
  assign stat.scan_done = !(n_rd < limit) && !ev_valid;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= NV_RESET;
      edge_vld     <= '0;
      visited      <= '0;
      head         <= '0;
      tail         <= '0;
      ev_valid     <= 1'b0;
      done         <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_vertices <= cfg_wdata;
      end
      if (cmd.wr_edge) begin
        edge_vld[waddr] <= 1'b1;
      end
      if (cmd.init) begin
        visited <= {{(MAX_V-1){1'b0}}, 1'b1} << item.start_vertex;
        head    <= '0;
        tail    <= CNT_W'(1);
      end else begin
        if (cmd.deq) begin
          head <= head + CNT_W'(1);
        end
        if (hit) begin
          visited[ev_n] <= 1'b1;
          tail          <= tail + CNT_W'(1);
        end
      end
      ev_valid <= issue;
      done     <= cmd.finish;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      goal                      <= item.goal_vertex;
      limit                     <= (num_vertices > NV_W'(MAX_V)) ? CNT_W'(MAX_V)
                                                                 : CNT_W'(num_vertices);
      queue[0]                  <= item.start_vertex;
      reach[item.start_vertex]  <= '0;
      n_rd                      <= '0;
    end
    if (cmd.deq) begin
      cur_v    <= head_v;
      cur_dist <= reach[head_v];
      n_rd     <= '0;
    end
    if (issue) begin
      n_rd   <= n_rd + CNT_W'(1);
      ev_n   <= n_rd[VERT_W-1:0];
      ev_vld <= edge_vld[raddr];
    end
    if (hit) begin
      reach[ev_n]                <= sum_sat;
      queue[tail[VERT_W-1:0]]    <= ev_n;
    end
    if (cmd.finish) begin
      result.route_found    <= cmd.found;
      result.total_distance <= cmd.found ? reach[head_v] : '0;
    end
  end

endmodule

// ===== hdl/bfs_route_distance.sv =====
// bfs_route_distance: top level of the breadth-first route search block.
// Depends on brd_pkg, brd_ctrl, brd_dp (and brd_ram below it).
//
// Usage:
//   Input words arrive on item and are taken at a clock edge with start
//   high and busy low. op = edge write stores one (from, to) entry of the
//   edge matrix (present bit and length) in the same edge; busy stays low
//   and no result word is produced, so writes can go back to back.
//   op = query starts a breadth-first search from start_vertex toward
//   goal_vertex; busy rises on the next cycle and holds until the answer.
//   The answer is on result for exactly one cycle with done high, in the
//   same cycle busy drops; the receiver cannot hold it off.
//   A query runs a setup step, then per dequeued vertex a dequeue step
//   and a scan of its L matrix entries, L = min(num_vertices, 16), and
//   ends with the dequeue step that finds the goal or an empty queue.
//   The rate is set by the edge RAM read port: one matrix entry per cycle.
//   num_vertices is to be written through cfg_we / cfg_wdata only while
//   idle; this binds the user, as the block itself does not enforce it.
//   Reset (rst, synchronous) clears the edge matrix through per-entry
//   valid flops at once, sets num_vertices to 16 and returns to idle.
module bfs_route_distance import brd_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  item_t           item,
  input  logic            cfg_we,
  input  logic [NV_W-1:0] cfg_wdata,
  output logic            done,
  output result_t         result
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing: idle, dequeue, neighbor scan
  brd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (item.op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // matrix storage, queue, visited set and distances
  brd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

  // an answer only ever closes a search
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result word without a running search");

  // controller is back to idle when the answer shows
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("still busy while result word is shown");

  // no route means zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.route_found) |-> (result.total_distance == '0))
    else $error("distance reported without a route");

  // an accepted query always starts a search
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_QUERY) |=> busy)
    else $error("accepted query did not start a search");

endmodule
